// File: hw/rtl/ncfb_pkg.sv
`timescale 1ns / 1ps

package ncfb_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [5:0] SIZE_RESET = 6'd8;
	localparam logic [5:0] SIZE_MIN = 6'd1;
	localparam logic [5:0] SIZE_MAX = 6'd32;

	localparam logic [7:0] PREAMBLE_BYTE = 8'hCC;
	localparam logic [7:0] SEQUENCE_BYTE = 8'h01;
	localparam logic [3:0] NIB_B = 4'hB;
	localparam logic [3:0] NIB_C = 4'hC;

	localparam logic [2:0] KIND_PREAMBLE = 3'd0;
	localparam logic [2:0] KIND_FNUM = 3'd1;
	localparam logic [2:0] KIND_SEQ = 3'd2;
	localparam logic [2:0] KIND_LEN = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD = 3'd4;
	localparam logic [2:0] KIND_CHECK = 3'd5;

	localparam logic [3:0] STEP_PRE0 = 4'd0;
	localparam logic [3:0] STEP_PRE1 = 4'd1;
	localparam logic [3:0] STEP_PRE2 = 4'd2;
	localparam logic [3:0] STEP_PRE3 = 4'd3;
	localparam logic [3:0] STEP_FNUM_HI = 4'd4;
	localparam logic [3:0] STEP_FNUM_LO = 4'd5;
	localparam logic [3:0] STEP_SEQ = 4'd6;
	localparam logic [3:0] STEP_LEN_HI = 4'd7;
	localparam logic [3:0] STEP_LEN_LO = 4'd8;
	localparam logic [3:0] STEP_PAYLOAD = 4'd9;
	localparam logic [3:0] STEP_CHECK_B = 4'd10;
	localparam logic [3:0] STEP_CHECK_C = 4'd11;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} ncfb_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [2:0] byte_kind;
		logic       frame_end;
		logic       last_of_run;
	} ncfb_out_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        hdr;
		logic        chk;
		logic [15:0] fnum;
		logic [5:0]  size;
		logic [5:0]  cnt_b;
		logic [5:0]  cnt_c;
	} ncfb_job_t;

endpackage

// File: hw/rtl/ncfb_front.sv
`timescale 1ns / 1ps

module ncfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	input  logic              in_valid,
	input  ncfb_pkg::ncfb_in_t in_word,
	input  logic              q_full,
	output logic              q_push,
	output ncfb_pkg::ncfb_job_t q_job
);

	logic [5:0]  bpf_q;
	logic [15:0] fnum_q;
	logic [5:0]  bif_q;
	logic [5:0]  cnt_b_q;
	logic [5:0]  cnt_c_q;

	logic [5:0] size_eff;
	logic       hdr;
	logic       has_b;
	logic       has_c;
	logic [5:0] new_b;
	logic [5:0] new_c;
	logic [5:0] new_bif;
	logic       close;

	always_comb begin
		if (bpf_q == 6'd0) begin
			size_eff = ncfb_pkg::SIZE_MIN;
		end else if (bpf_q > ncfb_pkg::SIZE_MAX) begin
			size_eff = ncfb_pkg::SIZE_MAX;
		end else begin
			size_eff = bpf_q;
		end
		hdr = (bif_q == 6'd0);
		has_b = (in_word.data_byte[7:4] == ncfb_pkg::NIB_B) ||
			(in_word.data_byte[3:0] == ncfb_pkg::NIB_B);
		has_c = (in_word.data_byte[7:4] == ncfb_pkg::NIB_C) ||
			(in_word.data_byte[3:0] == ncfb_pkg::NIB_C);
		new_b = (hdr ? 6'd0 : cnt_b_q) + {5'd0, has_b};
		new_c = (hdr ? 6'd0 : cnt_c_q) + {5'd0, has_c};
		new_bif = bif_q + 6'd1;
		close = (new_bif >= size_eff) || in_word.end_of_message;

		q_push = in_valid && !q_full;
		q_job.data_byte = in_word.data_byte;
		q_job.hdr = hdr;
		q_job.chk = close;
		q_job.fnum = fnum_q;
		q_job.size = size_eff;
		q_job.cnt_b = new_b;
		q_job.cnt_c = new_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpf_q <= ncfb_pkg::SIZE_RESET;
			fnum_q <= 16'd1;
			bif_q <= 6'd0;
			cnt_b_q <= 6'd0;
			cnt_c_q <= 6'd0;
		end else begin
			if (cfg_we) begin
				bpf_q <= cfg_wdata;
			end
			if (q_push) begin
				if (close) begin
					fnum_q <= fnum_q + 16'd1;
					bif_q <= 6'd0;
					cnt_b_q <= 6'd0;
					cnt_c_q <= 6'd0;
				end else begin
					bif_q <= new_bif;
					cnt_b_q <= new_b;
					cnt_c_q <= new_c;
				end
			end
		end
	end

	a_bif_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		bif_q <= ncfb_pkg::SIZE_MAX)
		else $error("frame byte count beyond largest frame");

endmodule

// File: hw/rtl/ncfb_fifo.sv
`timescale 1ns / 1ps

module ncfb_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ncfb_pkg::ncfb_job_t wdata,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output ncfb_pkg::ncfb_job_t rdata
);

	ncfb_pkg::ncfb_job_t mem_q [ncfb_pkg::QDEPTH];
	logic [ncfb_pkg::QAW-1:0] wr_ptr_q;
	logic [ncfb_pkg::QAW-1:0] rd_ptr_q;
	logic [ncfb_pkg::QAW:0]   count_q;

	assign full = (count_q == (ncfb_pkg::QAW+1)'(ncfb_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

// File: hw/rtl/ncfb_back.sv
`timescale 1ns / 1ps

module ncfb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ncfb_pkg::ncfb_job_t q_job,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output ncfb_pkg::ncfb_out_t out_word
);

	ncfb_pkg::ncfb_job_t cur_q;
	logic                cur_valid_q;
	logic [3:0]          step_q;
	logic                out_valid_q;
	ncfb_pkg::ncfb_out_t out_q;

	logic                advance;
	logic                emit;
	logic [3:0]          end_step;
	logic                done;
	ncfb_pkg::ncfb_out_t word;

	always_comb begin
		advance = !out_valid_q || !out_stall;
		emit = cur_valid_q && advance;
		end_step = cur_q.chk ? ncfb_pkg::STEP_CHECK_C : ncfb_pkg::STEP_PAYLOAD;
		done = emit && (step_q == end_step);
		q_pop = !q_empty && (!cur_valid_q || done);

		word.frame_end = 1'b0;
		word.last_of_run = (step_q == end_step);
		unique case (step_q) inside
			ncfb_pkg::STEP_PRE0, ncfb_pkg::STEP_PRE1,
			ncfb_pkg::STEP_PRE2, ncfb_pkg::STEP_PRE3: begin
				word.frame_byte = ncfb_pkg::PREAMBLE_BYTE;
				word.byte_kind = ncfb_pkg::KIND_PREAMBLE;
			end
			ncfb_pkg::STEP_FNUM_HI: begin
				word.frame_byte = cur_q.fnum[15:8];
				word.byte_kind = ncfb_pkg::KIND_FNUM;
			end
			ncfb_pkg::STEP_FNUM_LO: begin
				word.frame_byte = cur_q.fnum[7:0];
				word.byte_kind = ncfb_pkg::KIND_FNUM;
			end
			ncfb_pkg::STEP_SEQ: begin
				word.frame_byte = ncfb_pkg::SEQUENCE_BYTE;
				word.byte_kind = ncfb_pkg::KIND_SEQ;
			end
			ncfb_pkg::STEP_LEN_HI: begin
				word.frame_byte = 8'h00;
				word.byte_kind = ncfb_pkg::KIND_LEN;
			end
			ncfb_pkg::STEP_LEN_LO: begin
				word.frame_byte = {2'b00, cur_q.size};
				word.byte_kind = ncfb_pkg::KIND_LEN;
			end
			ncfb_pkg::STEP_CHECK_B: begin
				word.frame_byte = {2'b00, cur_q.cnt_b};
				word.byte_kind = ncfb_pkg::KIND_CHECK;
			end
			ncfb_pkg::STEP_CHECK_C: begin
				word.frame_byte = {2'b00, cur_q.cnt_c};
				word.byte_kind = ncfb_pkg::KIND_CHECK;
				word.frame_end = 1'b1;
			end
			default: begin
				word.frame_byte = cur_q.data_byte;
				word.byte_kind = ncfb_pkg::KIND_PAYLOAD;
			end
		endcase
	end

	// hold the job and output payload while stalled
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end
		if (advance) begin
			out_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q <= ncfb_pkg::STEP_PRE0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q <= q_job.hdr ? ncfb_pkg::STEP_PRE0 : ncfb_pkg::STEP_PAYLOAD;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= cur_valid_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_q;

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> step_q <= ncfb_pkg::STEP_CHECK_C)
		else $error("step counter past last check byte");

	a_frame_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_end |-> out_q.last_of_run &&
			out_q.byte_kind == ncfb_pkg::KIND_CHECK)
		else $error("frame end on a word that does not close the run");

endmodule

// File: hw/rtl/nibble_count_frame_builder.sv
`timescale 1ns / 1ps
// An input item is written into the job queue, popped into the job register and built
// into words in the output register. Throughput: one output word per cycle while
// out_stall is low; an item gives 1, 3, 10 or 12 words. A four-entry job queue lets
// the input run ahead of the output, and an input word may be taken every cycle while
// it has room. Reset: arst_n clears the queue and output valid, frame number to 1,
// counts to zero and the frame size register to 8; no clearing pass is needed.
module nibble_count_frame_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  ncfb_pkg::ncfb_in_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output ncfb_pkg::ncfb_out_t out_word
);

	logic                q_full;
	logic                q_push;
	logic                q_empty;
	logic                q_pop;
	ncfb_pkg::ncfb_job_t job_in;
	ncfb_pkg::ncfb_job_t job_out;

	assign in_stall = q_full;

	ncfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_word  (in_word),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (job_in)
	);

	ncfb_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (job_in),
		.full  (q_full),
		.pop   (q_pop),
		.empty (q_empty),
		.rdata (job_out)
	);

	ncfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_job    (job_out),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import ncfb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = 6'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	ncfb_in_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ncfb_out_t out_word;

	nibble_count_frame_builder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ncfb_in_t pending_bytes[$];
	ncfb_out_t expected_words[$];
	int mismatch_count = 0;
	bit in_idle_on = 1'b0;
	bit out_idle_on = 1'b0;
	int in_gap_left = 0;
	int stall_left = 0;

	// predicted state of the frame builder
	logic [5:0] size_reg = SIZE_RESET;
	logic [15:0] frame_no = 16'd1;
	logic [5:0] frame_fill = 6'd0;
	logic [5:0] count_b = 6'd0;
	logic [5:0] count_c = 6'd0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 90)
			return $urandom_range(3, 6);
		else
			return $urandom_range(10, 30);
	endfunction

	function automatic logic [7:0] pick_payload();
		case ($urandom_range(0, 3))
			0: begin
				return {NIB_B, 4'($urandom_range(0, 15))};
			end
			1: begin
				return {4'($urandom_range(0, 15)), NIB_C};
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic bit has_nib(input logic [7:0] b, input logic [3:0] nib);
		return b[7:4] == nib || b[3:0] == nib;
	endfunction

	task automatic add_word(input logic [7:0] b, input logic [2:0] kind, input logic fend);
		ncfb_out_t w;
		w.frame_byte = b;
		w.byte_kind = kind;
		w.frame_end = fend;
		w.last_of_run = 1'b0;
		expected_words.push_back(w);
	endtask

	task automatic build_frame_words(input ncfb_in_t item);
		logic [5:0] eff;
		ncfb_out_t w;
		eff = size_reg;
		if (eff < SIZE_MIN)
			eff = SIZE_MIN;
		if (eff > SIZE_MAX)
			eff = SIZE_MAX;
		if (frame_fill == 6'd0) begin
			repeat (4) add_word(PREAMBLE_BYTE, KIND_PREAMBLE, 1'b0);
			add_word(frame_no[15:8], KIND_FNUM, 1'b0);
			add_word(frame_no[7:0], KIND_FNUM, 1'b0);
			add_word(SEQUENCE_BYTE, KIND_SEQ, 1'b0);
			add_word(8'h00, KIND_LEN, 1'b0);
			add_word({2'b00, eff}, KIND_LEN, 1'b0);
			count_b = 6'd0;
			count_c = 6'd0;
		end
		add_word(item.data_byte, KIND_PAYLOAD, 1'b0);
		if (has_nib(item.data_byte, NIB_B))
			count_b = count_b + 6'd1;
		if (has_nib(item.data_byte, NIB_C))
			count_c = count_c + 6'd1;
		frame_fill = frame_fill + 6'd1;
		if (frame_fill >= eff || item.end_of_message) begin
			add_word({2'b00, count_b}, KIND_CHECK, 1'b0);
			add_word({2'b00, count_c}, KIND_CHECK, 1'b1);
			frame_no = frame_no + 16'd1;
			frame_fill = 6'd0;
			count_b = 6'd0;
			count_c = 6'd0;
		end
		w = expected_words.pop_back();
		w.last_of_run = 1'b1;
		expected_words.push_back(w);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				build_frame_words(in_word);
				if (in_idle_on && $urandom_range(0, 2) == 0)
					in_gap_left = pick_gap();
			end
			if (in_valid && in_stall) begin
				// hold the stalled word
			end else if (in_gap_left != 0) begin
				in_gap_left--;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				in_word <= pending_bytes.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		ncfb_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word %h", out_word);
					mismatch_count++;
				end else begin
					want = expected_words.pop_front();
					if (out_word.frame_byte !== want.frame_byte) begin
						$error("frame_byte: expected %02h, got %02h",
							want.frame_byte, out_word.frame_byte);
						mismatch_count++;
					end
					if (out_word.byte_kind !== want.byte_kind) begin
						$error("byte_kind: expected %0d, got %0d",
							want.byte_kind, out_word.byte_kind);
						mismatch_count++;
					end
					if (out_word.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b",
							want.frame_end, out_word.frame_end);
						mismatch_count++;
					end
					if (out_word.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							want.last_of_run, out_word.last_of_run);
						mismatch_count++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (out_idle_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic eom);
		ncfb_in_t item;
		item.data_byte = b;
		item.end_of_message = eom;
		pending_bytes.push_back(item);
	endtask

	task automatic queue_messages(input int n_items);
		int left;
		int len;
		bit eom;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			if (len > left)
				len = left;
			eom = $urandom_range(0, 5) != 0;
			for (int i = 0; i < len; i++)
				push_byte(pick_payload(), eom && i == len - 1);
			left -= len;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_frame_size(input logic [5:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = v;
	endtask

	initial begin
		logic [5:0] phase_sizes [10];
		phase_sizes = '{6'd1, 6'd33, 6'd32, 6'd5, 6'd8, 6'd3, 6'd17, 6'd0, 6'd63,
			6'($urandom_range(0, 63))};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// frame size from reset: one full frame, then a one-byte message
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hBB, 1'b0);
		push_byte(8'hCC, 1'b0);
		push_byte(8'hBC, 1'b0);
		push_byte(8'h1B, 1'b0);
		push_byte(8'hC2, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h0C, 1'b1);
		wait_drained();

		// zero acts as one
		write_frame_size(6'd0);
		push_byte(8'hB0, 1'b0);
		push_byte(8'h7E, 1'b1);
		wait_drained();

		// all ones acts as the maximum; leave the frame open
		in_idle_on = 1'b0;
		write_frame_size(6'd63);
		push_byte(8'hCB, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'h3C, 1'b0);
		wait_drained();

		// shrink below the open frame's fill: it closes on the next byte
		out_idle_on = 1'b0;
		write_frame_size(6'd2);
		push_byte(8'h81, 1'b0);
		push_byte(8'h42, 1'b0);
		push_byte(8'h24, 1'b1);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			in_idle_on = (p % 3) != 2;
			out_idle_on = (p % 4) != 3;
			write_frame_size(phase_sizes[p]);
			queue_messages(9);
			wait_drained();
		end

		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		write_frame_size(SIZE_RESET);
		queue_messages(12);
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("** nibble_count_frame_builder: PASSED **");
		else
			$display("** nibble_count_frame_builder: FAILED **");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("** nibble_count_frame_builder: FAILED **");
		$finish;
	end

endmodule
